// ----- rtl/bfr_pkg.sv -----
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared types and constants for the byte queue with rewind mark.
// ----------------------------------------------------------------------------
package bfr_pkg;

    // built depth of the slot memory
    localparam int DEPTH = 256;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // fixed field widths
    localparam int OP_W   = 3;
    localparam int BYTE_W = 8;
    localparam int CAP_W  = 9;

    // byte returned by a pop of an empty queue
    localparam logic [BYTE_W-1:0] EMPTY_BYTE = 8'hFF;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH       = 3'd0,
        OP_POP        = 3'd1,
        OP_PEEK_OLD   = 3'd2,
        OP_PEEK_NEW   = 3'd3,
        OP_MARK_SET   = 3'd4,
        OP_MARK_CLR   = 3'd5,
        OP_REWIND     = 3'd6,
        OP_CLEAR      = 3'd7
    } opcode_t;

endpackage

// ----- rtl/bfr_cmd_if.sv -----
// ----------------------------------------------------------------------------
// bfr_cmd_if
// Command channel: one queue operation per transfer.
// ----------------------------------------------------------------------------
interface bfr_cmd_if
    import bfr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [BYTE_W-1:0] push_byte;

    modport source (output valid, output opcode, output push_byte, input ready);
    modport sink   (input valid, input opcode, input push_byte, output ready);
endinterface

// ----- rtl/bfr_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bfr_rsp_if
// Response channel: one result per command.
// ----------------------------------------------------------------------------
interface bfr_rsp_if
    import bfr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              ok;
    logic [BYTE_W-1:0] read_byte;
    logic [CAP_W-1:0]  count;
    logic              empty_res;
    logic              full_res;

    modport source (output valid, output ok, output read_byte, output count,
                    output empty_res, output full_res, input ready);
    modport sink   (input valid, input ok, input read_byte, input count,
                    input empty_res, input full_res, output ready);
endinterface

// ----- rtl/byte_fifo_with_rewind_mark.sv -----
// ----------------------------------------------------------------------------
// byte_fifo_with_rewind_mark
// Circular byte queue with configurable capacity and a rewind mark.
// ----------------------------------------------------------------------------
// One command is taken per clock cycle and its result appears in the output
// register on the next cycle; the pace is set by that single output register,
// which releases a slot whenever the consumer takes the result in the same
// cycle. All queue state is updated in one pass per command, rewind included
// (closed form), and the slot memory uses one write port and one registered
// read port. Slots need no clearing after reset. A capacity write empties the
// queue and must be issued while no command is in flight.
module byte_fifo_with_rewind_mark
    import bfr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    bfr_cmd_if.sink          cmd,
    bfr_rsp_if.source        rsp
);

    localparam int SUM_W = CNT_W + 1;

    // queue state
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic             mark_on_reg, mark_on_next;
    logic [IDX_W-1:0] mark_reg, mark_next;
    logic [CNT_W-1:0] cap_reg;

    // result register
    logic             rsp_valid_reg;
    logic             ok_reg, ok_next;
    logic             rd_mem_reg, rd_mem_next;
    logic             rd_ff_reg, rd_ff_next;
    logic [CNT_W-1:0] count_reg;
    logic             empty_reg;
    logic             full_reg, full_next;

    // slot memory
    logic [BYTE_W-1:0] slots [DEPTH];
    logic [BYTE_W-1:0] mem_q;
    logic              wr_en;
    logic [IDX_W-1:0]  rd_addr;

    logic    xfer;
    opcode_t op;

    // wide working copies
    logic [SUM_W-1:0] cap_w, head_w, tail_w, mark_w;
    logic [SUM_W-1:0] tail_inc, head_inc, d_mark, d_tail, steps, head_back;
    logic [CNT_W-1:0] cap_eff;

    // effective capacity of a register write
    always_comb
    begin
        if (cfg_wdata == '0)
            cap_eff = CNT_W'(1);
        else if (cfg_wdata > CAP_W'(DEPTH))
            cap_eff = CNT_W'(DEPTH);
        else
            cap_eff = cfg_wdata[CNT_W-1:0];
    end

    assign xfer = cmd.valid && cmd.ready;
    assign op   = opcode_t'(cmd.opcode);

    assign cmd.ready = !rsp_valid_reg || rsp.ready;

    // index arithmetic
    assign cap_w    = SUM_W'(cap_reg);
    assign head_w   = SUM_W'(head_reg);
    assign tail_w   = SUM_W'(tail_reg);
    assign mark_w   = SUM_W'(mark_reg);
    assign tail_inc = tail_w + SUM_W'(1);
    assign head_inc = head_w + SUM_W'(1);

    // rewind distances
    always_comb
    begin
        d_mark = (head_w >= mark_w) ? head_w - mark_w : head_w + cap_w - mark_w;
        d_tail = (head_w >= tail_w) ? head_w - tail_w : head_w + cap_w - tail_w;
        if (d_tail == '0)
            d_tail = cap_w;
        steps     = (d_mark < d_tail) ? d_mark : d_tail;
        head_back = (head_w >= steps) ? head_w - steps : head_w + cap_w - steps;
    end

    // operation decode
    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        held_next    = held_reg;
        mark_on_next = mark_on_reg;
        mark_next    = mark_reg;
        ok_next      = 1'b1;
        rd_mem_next  = 1'b0;
        rd_ff_next   = 1'b0;
        wr_en        = 1'b0;
        rd_addr      = head_reg;
        unique case (op)
            OP_PUSH:
            begin
                if (held_reg < cap_reg)
                begin
                    wr_en     = 1'b1;
                    tail_next = (tail_inc >= cap_w) ? '0 : tail_inc[IDX_W-1:0];
                    held_next = held_reg + CNT_W'(1);
                end
                else
                    ok_next = 1'b0;
            end
            OP_POP:
            begin
                if (held_reg != '0)
                begin
                    rd_mem_next = 1'b1;
                    head_next   = (head_inc >= cap_w) ? '0 : head_inc[IDX_W-1:0];
                    held_next   = held_reg - CNT_W'(1);
                end
                else
                begin
                    ok_next    = 1'b0;
                    rd_ff_next = 1'b1;
                end
            end
            OP_PEEK_OLD:
            begin
                if (held_reg != '0)
                    rd_mem_next = 1'b1;
                else
                    ok_next = 1'b0;
            end
            OP_PEEK_NEW:
            begin
                rd_addr = (tail_reg == '0) ? IDX_W'(cap_reg - CNT_W'(1))
                                           : tail_reg - IDX_W'(1);
                if (held_reg != '0)
                    rd_mem_next = 1'b1;
                else
                    ok_next = 1'b0;
            end
            OP_MARK_SET:
            begin
                mark_on_next = 1'b1;
                mark_next    = head_reg;
            end
            OP_MARK_CLR:
                mark_on_next = 1'b0;
            OP_REWIND:
            begin
                if (mark_on_reg && held_reg < cap_reg)
                begin
                    head_next = head_back[IDX_W-1:0];
                    held_next = held_reg + steps[CNT_W-1:0];
                end
            end
            OP_CLEAR:
            begin
                head_next    = '0;
                tail_next    = '0;
                held_next    = '0;
                mark_on_next = 1'b0;
                mark_next    = '0;
            end
            default: ;
        endcase
        full_next = (held_next == cap_reg) ||
                    (mark_on_next && held_next != '0 && tail_next == mark_next);
    end

    // queue state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            held_reg      <= '0;
            mark_on_reg   <= 1'b0;
            mark_reg      <= '0;
            cap_reg       <= CNT_W'(DEPTH);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg     <= cap_eff;
                head_reg    <= '0;
                tail_reg    <= '0;
                held_reg    <= '0;
                mark_on_reg <= 1'b0;
                mark_reg    <= '0;
            end
            else if (xfer)
            begin
                head_reg    <= head_next;
                tail_reg    <= tail_next;
                held_reg    <= held_next;
                mark_on_reg <= mark_on_next;
                mark_reg    <= mark_next;
            end
            if (xfer)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            ok_reg     <= ok_next;
            rd_mem_reg <= rd_mem_next;
            rd_ff_reg  <= rd_ff_next;
            count_reg  <= held_next;
            empty_reg  <= (held_next == '0);
            full_reg   <= full_next;
        end
    end

    // slot memory write
    always_ff @(posedge clk)
    begin
        if (xfer && wr_en)
            slots[tail_reg] <= cmd.push_byte;
    end

    // slot memory registered read
    always_ff @(posedge clk)
    begin
        if (xfer && rd_mem_next)
            mem_q <= slots[rd_addr];
    end

    // response port
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.ok        = ok_reg;
    assign rsp.read_byte = rd_mem_reg ? mem_q : (rd_ff_reg ? EMPTY_BYTE : '0);
    assign rsp.count     = CAP_W'(count_reg);
    assign rsp.empty_res = empty_reg;
    assign rsp.full_res  = full_reg;

endmodule

// ----- rtl/bfr_checker.sv -----
// ----------------------------------------------------------------------------
// bfr_checker
// Port-level checks for the byte queue with rewind mark.
// ----------------------------------------------------------------------------
module bfr_checker
    import bfr_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             cmd_valid,
    input logic             cmd_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic             rsp_ok,
    input logic [CAP_W-1:0] rsp_count,
    input logic             rsp_empty,
    input logic             rsp_full
);

    // every command transfer yields a result on the next cycle
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> rsp_valid)
        else $error("no result after command transfer");

    // commands stall only behind a result that is not taken
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> rsp_valid && !rsp_ready)
        else $error("command stalled without pending result");

    // empty flag matches the count
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_empty == (rsp_count == '0)))
        else $error("empty flag disagrees with count");

    // a failed operation sees an empty or a full queue
    a_fail_cause: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ok |-> rsp_empty || rsp_full)
        else $error("failed operation on a queue neither empty nor full");

    // count never passes the built depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_count <= CAP_W'(DEPTH))
        else $error("count above depth");

endmodule

bind byte_fifo_with_rewind_mark bfr_checker u_bfr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_ok    (rsp.ok),
    .rsp_count (rsp.count),
    .rsp_empty (rsp.empty_res),
    .rsp_full  (rsp.full_res)
);
